// ===== rtl/mik_pkg.sv =====
// Shared types, item codes and Morse character tables for the ident keyer.
package mik_pkg;

    // Item codes carried on the mode field; the unused code acts as a tick
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam int PAT_W = 19;
    localparam int CNT_W = 5;

    // Special ASCII codes
    localparam logic [7:0] CHAR_SPACE      = 8'd32;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
    localparam logic [7:0] CHAR_SLASH      = 8'd47;
    localparam logic [7:0] CHAR_DIGIT_LO   = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_HI   = 8'd57;
    localparam logic [7:0] CHAR_UPPER_LO   = 8'd65;
    localparam logic [7:0] CHAR_UPPER_HI   = 8'd90;
    localparam logic [7:0] CHAR_LOWER_MIN  = 8'd96;
    localparam logic [7:0] CASE_OFFSET     = 8'd32;

    // Word gap length, slash pattern and inter-character gap
    localparam logic [CNT_W-1:0] WORD_GAP_BITS = 5'd7;
    localparam logic [PAT_W-1:0] SLASH_PAT     = 19'h01757;
    localparam logic [CNT_W-1:0] SLASH_BITS    = 5'd16;
    localparam logic [CNT_W-1:0] CHAR_GAP_BITS = 5'd3;

    localparam logic [PAT_W-1:0] LETTER_PAT [26] = '{
        19'h0001D, 19'h00157, 19'h005D7, 19'h00057, 19'h00001, 19'h00175,
        19'h00177, 19'h00055, 19'h00005, 19'h01DDD, 19'h001D7, 19'h0015D,
        19'h00077, 19'h00017, 19'h00777, 19'h005DD, 19'h01D77, 19'h0005D,
        19'h00015, 19'h00007, 19'h00075, 19'h001D5, 19'h001DD, 19'h00757,
        19'h01DD7, 19'h00577};
    localparam logic [CNT_W-1:0] LETTER_LEN [26] = '{
        5'd5, 5'd9, 5'd11, 5'd7, 5'd1, 5'd9, 5'd9, 5'd7, 5'd3, 5'd13, 5'd9,
        5'd9, 5'd7, 5'd5, 5'd11, 5'd11, 5'd13, 5'd7, 5'd5, 5'd3, 5'd7, 5'd9,
        5'd9, 5'd11, 5'd13, 5'd11};
    localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
        19'h77777, 19'h1DDDD, 19'h07775, 19'h01DD5, 19'h00755, 19'h00155,
        19'h00557, 19'h01577, 19'h05777, 19'h17777};
    localparam logic [CNT_W-1:0] DIGIT_LEN [10] = '{
        5'd19, 5'd17, 5'd15, 5'd13, 5'd11, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17};

    // Key pattern (LSB first) and total bit length of one character
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [CNT_W-1:0] bits;
    } char_code_t;

    // Map an ASCII code to its Morse pattern; unknown codes give length zero
    function automatic char_code_t char_code(input logic [7:0] c);
        char_code_t r;
        logic [7:0] upper;
        logic [7:0] dig_idx;
        logic [7:0] let_idx;
        r.pattern = '0;
        r.bits    = '0;
        upper   = (c > CHAR_LOWER_MIN) ? c - CASE_OFFSET : c;
        dig_idx = c - CHAR_DIGIT_LO;
        let_idx = upper - CHAR_UPPER_LO;
        if (c == CHAR_SPACE || c == CHAR_UNDERSCORE) begin
            r.bits = WORD_GAP_BITS;
        end else if (c == CHAR_SLASH) begin
            r.pattern = SLASH_PAT;
            r.bits    = SLASH_BITS;
        end else if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
            r.pattern = DIGIT_PAT[dig_idx[3:0]];
            r.bits    = DIGIT_LEN[dig_idx[3:0]] + CHAR_GAP_BITS;
        end else if (upper >= CHAR_UPPER_LO && upper <= CHAR_UPPER_HI) begin
            r.pattern = LETTER_PAT[let_idx[4:0]];
            r.bits    = LETTER_LEN[let_idx[4:0]] + CHAR_GAP_BITS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mik_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mik_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/morse_ident_keyer_unit.sv =====
// Morse ident keyer: stores an ident string and keys it out one tick per beat.
//
//  channel  | direction | signals                                   | beat moves
//  ---------+-----------+-------------------------------------------+----------------------
//  s_       | in        | s_valid s_ready s_mode s_write_index      | tick/write/restart
//           |           | s_write_char                              |
//  m_       | out       | m_valid m_ready m_key_level m_ident_done  | one result per input
//  cfg_     | in        | cfg_we cfg_wdata                          | ticks_per_bit write
//
// Each input beat's result appears in the output register on the next cycle;
// one beat per cycle is sustained while m_ready is high.
// The ident RAM is read one character ahead of the current position, so each
// tick can load the next character without waiting on the RAM read.
// A full output register with m_ready low stalls the input side.
// Reset marks every ident entry empty at once through per-entry valid bits.
module morse_ident_keyer_unit
    import mik_pkg::*;
#(
    parameter int IDENT_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [5:0] s_write_index,
    input  logic [7:0] s_write_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_key_level,
    output logic       m_ident_done,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam int AW = $clog2(IDENT_DEPTH);
    localparam int CW = (AW + 1 > 6) ? AW + 1 : 6;
    localparam logic [AW-1:0] LAST_POS = AW'(IDENT_DEPTH - 1);
    localparam logic [7:0]    TPB_RESET = 8'd5;

    logic [7:0]             tpb_reg;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]       bitpos_reg, bitpos_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             timer_reg, timer_next;
    logic [PAT_W-1:0]       pat_reg, pat_next;
    logic                   last_reg, last_next;
    logic [IDENT_DEPTH-1:0] valid_reg, valid_next;
    logic [7:0]             first_char_reg, first_char_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   byp_hit_reg, byp_hit_next;
    logic [7:0]             byp_data_reg;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_key_level_reg, m_key_level_next;
    logic                   m_ident_done_reg, m_ident_done_next;

    logic          in_beat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_rdata;
    logic [7:0]    next_char;
    logic          wrap;
    logic [7:0]    load_char;
    char_code_t    code;

    // Accept while the output register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    // Drop writes beyond the store
    assign wr_en   = in_beat && (s_mode == MODE_WRITE) &&
                     (CW'(s_write_index) < CW'(IDENT_DEPTH));
    assign wr_addr = AW'(s_write_index);

    // Character after the current one, with write forwarding and empty entries as zero
    assign next_char = byp_hit_reg  ? byp_data_reg :
                       rd_valid_reg ? ram_rdata    : 8'd0;
    assign wrap      = (pos_reg == LAST_POS) || (next_char == 8'd0);
    assign load_char = (s_mode == MODE_RESTART || wrap) ? first_char_reg : next_char;
    assign code      = char_code(load_char);

    // Advance the keyer state for one beat
    always_comb begin
        pos_next          = pos_reg;
        bitpos_next       = bitpos_reg;
        cnt_next          = cnt_reg;
        timer_next        = timer_reg;
        pat_next          = pat_reg;
        last_next         = last_reg;
        m_key_level_next  = last_reg;
        m_ident_done_next = 1'b0;
        if (in_beat) begin
            case (s_mode)
                MODE_WRITE: begin
                end
                MODE_RESTART: begin
                    pos_next         = '0;
                    bitpos_next      = '0;
                    timer_next       = '0;
                    last_next        = 1'b0;
                    pat_next         = code.pattern;
                    cnt_next         = code.bits;
                    m_key_level_next = 1'b0;
                end
                default: begin
                    if (timer_reg >= tpb_reg) begin
                        timer_next       = '0;
                        m_key_level_next = pat_reg[0];
                        last_next        = pat_reg[0];
                        pat_next         = pat_reg >> 1;
                        if (bitpos_reg >= cnt_reg) begin
                            bitpos_next       = '0;
                            pos_next          = wrap ? '0 : pos_reg + AW'(1);
                            m_ident_done_next = wrap;
                            pat_next          = code.pattern;
                            cnt_next          = code.bits;
                        end else begin
                            bitpos_next = bitpos_reg + CNT_W'(1);
                        end
                    end else begin
                        timer_next = timer_reg + 8'd1;
                    end
                end
            endcase
        end
    end

    // Prefetch the entry after the next position; forward a same-cycle write
    assign rd_addr = (pos_next == LAST_POS) ? '0 : pos_next + AW'(1);

    always_comb begin
        valid_next      = valid_reg;
        first_char_next = first_char_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
            if (wr_addr == '0) begin
                first_char_next = s_write_char;
            end
        end
        rd_valid_next = valid_reg[rd_addr];
        byp_hit_next  = wr_en && (wr_addr == rd_addr);
    end

    // Load or drain the result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and keyer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpb_reg        <= TPB_RESET;
            pos_reg        <= '0;
            bitpos_reg     <= '0;
            cnt_reg        <= '0;
            timer_reg      <= '0;
            pat_reg        <= '0;
            last_reg       <= 1'b0;
            valid_reg      <= '0;
            first_char_reg <= '0;
            rd_valid_reg   <= 1'b0;
            byp_hit_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                tpb_reg <= cfg_wdata;
            end
            pos_reg        <= pos_next;
            bitpos_reg     <= bitpos_next;
            cnt_reg        <= cnt_next;
            timer_reg      <= timer_next;
            pat_reg        <= pat_next;
            last_reg       <= last_next;
            valid_reg      <= valid_next;
            first_char_reg <= first_char_next;
            rd_valid_reg   <= rd_valid_next;
            byp_hit_reg    <= byp_hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byp_data_reg <= s_write_char;
        if (in_beat) begin
            m_key_level_reg  <= m_key_level_next;
            m_ident_done_reg <= m_ident_done_next;
        end
    end

    mik_ram #(
        .WIDTH (8),
        .DEPTH (IDENT_DEPTH)
    ) u_ident_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_write_char),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_key_level  = m_key_level_reg;
    assign m_ident_done = m_ident_done_reg;

endmodule

// ===== verif/morse_ident_keyer_unit_test.sv =====
// Testbench for the Morse ident keyer: directed table, random ident strings, in-order scoreboard.
module morse_ident_keyer_unit_test;
    import mik_pkg::*;

    // Spare mode code, keyed as a tick
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int         STORE_DEPTH   = 64;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [7:0] RATE_AT_RESET = 8'd5;

    // Character classes and Morse timing
    localparam logic [7:0]  ASC_SPACE  = 8'd32;
    localparam logic [7:0]  ASC_UNDER  = 8'd95;
    localparam logic [7:0]  ASC_SLASH  = 8'd47;
    localparam logic [7:0]  ASC_ZERO   = 8'd48;
    localparam logic [7:0]  ASC_NINE   = 8'd57;
    localparam logic [7:0]  ASC_A      = 8'd65;
    localparam logic [7:0]  ASC_Z      = 8'd90;
    localparam logic [7:0]  ASC_GRAVE  = 8'd96;
    localparam logic [7:0]  CASE_SHIFT = 8'd32;
    localparam logic [4:0]  GAP_LEN    = 5'd3;
    localparam logic [4:0]  WORD_LEN   = 5'd7;
    localparam logic [18:0] STROKE_PAT = 19'h01757;
    localparam logic [4:0]  STROKE_LEN = 5'd16;

    localparam logic [18:0] ALPHA_PAT [26] = '{
        19'h0001D, 19'h00157, 19'h005D7, 19'h00057, 19'h00001, 19'h00175, 19'h00177,
        19'h00055, 19'h00005, 19'h01DDD, 19'h001D7, 19'h0015D, 19'h00077, 19'h00017,
        19'h00777, 19'h005DD, 19'h01D77, 19'h0005D, 19'h00015, 19'h00007, 19'h00075,
        19'h001D5, 19'h001DD, 19'h00757, 19'h01DD7, 19'h00577};
    localparam logic [4:0] ALPHA_LEN [26] = '{
        5'd5, 5'd9, 5'd11, 5'd7, 5'd1, 5'd9, 5'd9, 5'd7, 5'd3, 5'd13, 5'd9, 5'd9, 5'd7,
        5'd5, 5'd11, 5'd11, 5'd13, 5'd7, 5'd5, 5'd3, 5'd7, 5'd9, 5'd9, 5'd11, 5'd13, 5'd11};
    localparam logic [18:0] NUM_PAT [10] = '{
        19'h77777, 19'h1DDDD, 19'h07775, 19'h01DD5, 19'h00755, 19'h00155, 19'h00557,
        19'h01577, 19'h05777, 19'h17777};
    localparam logic [4:0] NUM_LEN [10] = '{
        5'd19, 5'd17, 5'd15, 5'd13, 5'd11, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17};

    typedef struct packed {
        logic key;
        logic done;
    } key_beat_t;

    typedef struct packed {
        logic [18:0] pat;
        logic [4:0]  len;
    } morse_sym_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] idx;
        logic [7:0] ch;
        logic       fixed;
        key_beat_t  want;
    } stim_row_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode        = MODE_TICK;
    logic [5:0] s_write_index = 6'd0;
    logic [7:0] s_write_char  = 8'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_key_level;
    logic       m_ident_done;
    logic       cfg_we        = 1'b0;
    logic [7:0] cfg_wdata     = 8'd0;

    // Keyer shadow state
    logic [7:0]  rate_q;
    logic [7:0]  ident_q [STORE_DEPTH];
    int unsigned char_pos;
    logic [4:0]  bit_pos;
    logic [4:0]  bit_total;
    logic [7:0]  tick_cnt;
    logic [18:0] pat_q;
    logic        level_q;

    key_beat_t expected_beats [$];
    key_beat_t head_beat;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int idents_done    = 0;
    int rate_writes    = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // Directed table: fixed rows carry an expectation read straight off the spec
    stim_row_t directed_rows [24] = '{
        '{MODE_TICK,    6'd0,  8'h00, 1'b1, '{1'b0, 1'b0}},
        '{MODE_SPARE,   6'd63, 8'hFF, 1'b1, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd21, 8'hAA, 1'b1, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd42, 8'h55, 1'b1, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b1, '{1'b0, 1'b0}},
        // sixth tick reaches a bit boundary on an empty store
        '{MODE_TICK,    6'd0,  8'h00, 1'b1, '{1'b0, 1'b1}},
        '{MODE_WRITE,   6'd0,  "a",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd1,  "0",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd2,  "/",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd3,  " ",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd4,  "_",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd5,  "9",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd6,  "Z",   1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd7,  8'h80, 1'b1, '{1'b0, 1'b0}},
        '{MODE_WRITE,   6'd63, 8'hFF, 1'b1, '{1'b0, 1'b0}},
        '{MODE_RESTART, 6'd63, 8'hFF, 1'b1, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        '{MODE_SPARE,   6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        '{MODE_TICK,    6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}},
        // overwrite the character being keyed; the loaded pattern must stay
        '{MODE_WRITE,   6'd0,  "Q",   1'b0, '{1'b0, 1'b0}},
        '{MODE_SPARE,   6'd0,  8'h00, 1'b0, '{1'b0, 1'b0}}
    };

    morse_ident_keyer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_write_index (s_write_index),
        .s_write_char  (s_write_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_level   (m_key_level),
        .m_ident_done  (m_ident_done),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Map one ASCII code to its key pattern and bit count
    function automatic morse_sym_t morse_of(input logic [7:0] c);
        morse_sym_t s;
        logic [7:0] upper;
        logic [7:0] off;
        s = '0;
        upper = (c > ASC_GRAVE) ? c - CASE_SHIFT : c;
        if (c == ASC_SPACE || c == ASC_UNDER) begin
            s.len = WORD_LEN;
        end else if (c == ASC_SLASH) begin
            s.pat = STROKE_PAT;
            s.len = STROKE_LEN;
        end else if (c >= ASC_ZERO && c <= ASC_NINE) begin
            off   = c - ASC_ZERO;
            s.pat = NUM_PAT[off[3:0]];
            s.len = NUM_LEN[off[3:0]] + GAP_LEN;
        end else if (upper >= ASC_A && upper <= ASC_Z) begin
            off   = upper - ASC_A;
            s.pat = ALPHA_PAT[off[4:0]];
            s.len = ALPHA_LEN[off[4:0]] + GAP_LEN;
        end
        return s;
    endfunction

    // Advance the shadow keyer by one accepted beat and return the key it gives
    function automatic key_beat_t keyer_step(input logic [1:0] mode, input logic [5:0] idx,
                                             input logic [7:0] ch);
        key_beat_t  r;
        morse_sym_t s;
        r.key  = level_q;
        r.done = 1'b0;
        if (mode == MODE_WRITE) begin
            ident_q[idx] = ch;
        end else if (mode == MODE_RESTART) begin
            char_pos  = 0;
            bit_pos   = '0;
            tick_cnt  = '0;
            level_q   = 1'b0;
            s         = morse_of(ident_q[0]);
            pat_q     = s.pat;
            bit_total = s.len;
            r.key     = 1'b0;
        end else if (tick_cnt >= rate_q) begin
            tick_cnt = '0;
            r.key    = pat_q[0];
            level_q  = pat_q[0];
            pat_q    = pat_q >> 1;
            if (bit_pos >= bit_total) begin
                bit_pos  = '0;
                char_pos = char_pos + 1;
                if (char_pos >= STORE_DEPTH || ident_q[char_pos] == 8'd0) begin
                    char_pos = 0;
                    r.done   = 1'b1;
                end
                s         = morse_of(ident_q[char_pos]);
                pat_q     = s.pat;
                bit_total = s.len;
            end else begin
                bit_pos = bit_pos + 5'd1;
            end
        end else begin
            tick_cnt = tick_cnt + 8'd1;
        end
        return r;
    endfunction

    function automatic stim_row_t free_row(input logic [1:0] mode, input logic [5:0] idx,
                                           input logic [7:0] ch);
        stim_row_t row;
        row.mode  = mode;
        row.idx   = idx;
        row.ch    = ch;
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Nonzero character, weighted toward the keyable classes
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return 8'($urandom_range(ASC_A, ASC_Z));
        if (r < 46) return 8'($urandom_range(ASC_A, ASC_Z)) + CASE_SHIFT;
        if (r < 66) return 8'($urandom_range(ASC_ZERO, ASC_NINE));
        if (r < 71) return ASC_SLASH;
        if (r < 76) return ASC_SPACE;
        if (r < 81) return ASC_UNDER;
        if (r < 91) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(1, 127));
    endfunction

    // Present one beat, hold it until accepted, then log its expected result
    task automatic send_beat(input stim_row_t row);
        key_beat_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= row.mode;
        s_write_index <= row.idx;
        s_write_char  <= row.ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = keyer_step(row.mode, row.idx, row.ch);
        expected_beats.push_back(row.fixed ? row.want : predicted);
        beats_sent++;
    endtask

    // Ticks with random side fields and a sprinkle of arbitrary beats
    task automatic send_ticks(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_beat(free_row(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                                   8'($urandom_range(0, 255))));
            else
                send_beat(free_row((r < 10) ? MODE_SPARE : MODE_TICK,
                                   6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
        end
    endtask

    // Hold the sender until every expected result has been collected
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_rate(input logic [7:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        rate_q     = value;
        rate_writes++;
    endtask

    // One random phase: mostly spelled idents followed by ticks, some noise bursts
    task automatic run_phase(input int gap, input int stall, input logic [7:0] rate,
                             input int n_beats, input bit fill_store);
        int start;
        bit paused;
        int len;
        set_rate(rate);
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        start  = beats_sent;
        paused = 1'b0;
        // fill every entry so keying runs off the end of the store
        if (fill_store) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                send_beat(free_row(MODE_WRITE, 6'(i), ($urandom_range(0, 9) == 0) ?
                                   ASC_A + 8'd4 : 8'($urandom_range(1, 31))));
            send_beat(free_row(MODE_RESTART, 6'($urandom_range(0, 63)),
                               8'($urandom_range(0, 255))));
            send_ticks(130);
        end
        while (beats_sent - start < n_beats) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_beat(free_row(MODE_WRITE, 6'(i), pick_char()));
                send_beat(free_row(MODE_WRITE, 6'(len), 8'd0));
                send_beat(free_row(MODE_RESTART, 6'($urandom_range(0, 63)),
                                   8'($urandom_range(0, 255))));
                send_ticks($urandom_range(20, 90));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_beat(free_row(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                                       8'($urandom_range(0, 255))));
            end
            if (!paused && beats_sent - start >= n_beats / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // Collect results and compare against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: result with none expected: key_level %0b ident_done %0b",
                         $time, m_key_level, m_ident_done);
                mismatches++;
            end else begin
                head_beat = expected_beats.pop_front();
                if (head_beat.done)
                    idents_done++;
                if (m_key_level !== head_beat.key) begin
                    $display("%0t: key_level expected %0b actual %0b",
                             $time, head_beat.key, m_key_level);
                    mismatches++;
                end
                if (m_ident_done !== head_beat.done) begin
                    $display("%0t: ident_done expected %0b actual %0b",
                             $time, head_beat.done, m_ident_done);
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rate_q    = RATE_AT_RESET;
        char_pos  = 0;
        bit_pos   = '0;
        bit_total = '0;
        tick_cnt  = '0;
        pat_q     = '0;
        level_q   = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            ident_q[i] = 8'd0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        run_phase(0,  0,  8'd0,   40, 1'b1);
        run_phase(88, 0,  8'd255, 40, 1'b0);
        run_phase(0,  88, 8'd1,   40, 1'b0);
        run_phase(25, 25, 8'd0,   40, 1'b1);
        run_phase(0,  0,  8'd2,   40, 1'b0);
        run_phase(88, 0,  8'($urandom_range(3, 12)), 40, 1'b0);
        run_phase(0,  88, 8'd0,   40, 1'b0);

        drain_results();
        $display("Run covered %0d input beats, %0d results, %0d ident completions,",
                 beats_sent, results_seen, idents_done);
        $display("across %0d bit-rate settings and four sender/receiver idle patterns.",
                 rate_writes);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
